// ===== rtl/ospp_pkg.sv =====
package ospp_pkg;

  // Result kinds, as carried on out_tuser
  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR     = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_t;

  // Finished status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SYNTAX   = 2'd1,
    STAT_TOO_LONG = 2'd2
  } status_t;

  // Characters the parser looks for
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_DASH       = 8'h2d;
  localparam logic [7:0] CH_LOWER_C    = 8'h63;
  localparam logic [7:0] CH_EQUALS     = 8'h3d;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5c;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0d;

  // Defaults
  localparam int OSPP_MAX_VAR_BYTES = 64;
  localparam int OSPP_QUEUE_DEPTH   = 4;

  // Results caused by one input byte, in emission order: char, pair, finished
  typedef struct packed {
    logic    has_char;
    kind_t   char_kind;
    logic [7:0] char_data;
    logic    has_pair;
    logic    has_fin;
    status_t status;
  } bundle_t;

endpackage

// ===== rtl/ospp_front.sv =====
module ospp_front #(
  parameter int MAX_VAR_BYTES = ospp_pkg::OSPP_MAX_VAR_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             is_last,
  output logic             push,
  output ospp_pkg::bundle_t bundle
);
  import ospp_pkg::*;

  localparam int SEG_W = (MAX_VAR_BYTES > 2) ? $clog2(MAX_VAR_BYTES) : 1;
  localparam logic [SEG_W-1:0] SEG_LIMIT = SEG_W'(MAX_VAR_BYTES - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_DASH1, PH_OPT_C, PH_DASH2, PH_PAIR, PH_SILENT
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic             pair_exp_r, pair_exp_nxt;
  logic             seen_eq_r, seen_eq_nxt;
  status_t          fault_r, fault_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  bundle_t          bnd;

  // Per-byte parse: token handling, pair bytes, token end, string end
  always_comb begin
    logic sp;
    logic begin_pair;
    logic do_pair;
    logic tok_end;
    logic finish;
    sp = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
    begin_pair   = 1'b0;
    do_pair      = 1'b0;
    tok_end      = 1'b0;
    finish       = 1'b0;
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    pair_exp_nxt = pair_exp_r;
    seen_eq_nxt  = seen_eq_r;
    fault_nxt    = fault_r;
    seg_nxt      = seg_r;
    bnd          = '0;

    if (in_byte == CH_NUL) begin
      tok_end = 1'b1;
      finish  = 1'b1;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (!sp) begin
            if (pair_exp_r) begin
              pair_exp_nxt = 1'b0;
              begin_pair   = 1'b1;
            end else if (in_byte == CH_DASH) begin
              phase_nxt = PH_DASH1;
            end else begin
              if (fault_nxt == STAT_OK) fault_nxt = STAT_SYNTAX;
              phase_nxt = PH_SILENT;
            end
          end
        end
        PH_DASH1: begin
          if (sp) begin
            tok_end = 1'b1;
          end else if (in_byte == CH_LOWER_C) begin
            phase_nxt = PH_OPT_C;
          end else if (in_byte == CH_DASH) begin
            phase_nxt = PH_DASH2;
          end else begin
            if (fault_nxt == STAT_OK) fault_nxt = STAT_SYNTAX;
            phase_nxt = PH_SILENT;
          end
        end
        PH_OPT_C: begin
          if (sp) begin
            tok_end = 1'b1;
          end else begin
            if (fault_nxt == STAT_OK) fault_nxt = STAT_SYNTAX;
            phase_nxt = PH_SILENT;
          end
        end
        PH_DASH2: begin
          if (sp) tok_end = 1'b1;
          else    begin_pair = 1'b1;
        end
        PH_PAIR: begin
          if (sp && !esc_r) tok_end = 1'b1;
          else              do_pair = 1'b1;
        end
        default: ;
      endcase
      if (is_last) begin
        tok_end = 1'b1;
        finish  = 1'b1;
      end
    end

    // Start of a name=value token
    if (begin_pair) begin
      phase_nxt   = PH_PAIR;
      seen_eq_nxt = 1'b0;
      esc_nxt     = 1'b0;
      seg_nxt     = '0;
      do_pair     = 1'b1;
    end

    // One byte inside a pair
    if (do_pair) begin
      if (!seen_eq_nxt && (in_byte == CH_EQUALS)) begin
        seen_eq_nxt = 1'b1;
        esc_nxt     = 1'b0;
        seg_nxt     = '0;
      end else if (!esc_nxt && (in_byte == CH_BACKSLASH)) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (seg_nxt >= SEG_LIMIT) begin
          if (fault_nxt == STAT_OK) fault_nxt = STAT_TOO_LONG;
          phase_nxt = PH_SILENT;
        end else begin
          seg_nxt      = seg_nxt + 1'b1;
          bnd.has_char = 1'b1;
          if (seen_eq_nxt) begin
            bnd.char_kind = KIND_VALUE;
            bnd.char_data = in_byte;
          end else begin
            bnd.char_kind = KIND_NAME;
            bnd.char_data = (in_byte == CH_DASH) ? CH_UNDERSCORE : in_byte;
          end
        end
      end
    end

    // End of a token
    if (tok_end) begin
      case (phase_nxt)
        PH_DASH1, PH_DASH2: begin
          if (fault_nxt == STAT_OK) fault_nxt = STAT_SYNTAX;
          phase_nxt = PH_SILENT;
        end
        PH_OPT_C: begin
          pair_exp_nxt = 1'b1;
          phase_nxt    = PH_IDLE;
        end
        PH_PAIR: begin
          if (seen_eq_nxt) begin
            bnd.has_pair = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            if (fault_nxt == STAT_OK) fault_nxt = STAT_SYNTAX;
            phase_nxt = PH_SILENT;
          end
        end
        default: ;
      endcase
      esc_nxt = 1'b0;
    end

    // End of the string: report and return to the reset state
    if (finish) begin
      if (pair_exp_nxt && (fault_nxt == STAT_OK)) fault_nxt = STAT_SYNTAX;
      bnd.has_fin  = 1'b1;
      bnd.status   = fault_nxt;
      phase_nxt    = PH_IDLE;
      esc_nxt      = 1'b0;
      pair_exp_nxt = 1'b0;
      seen_eq_nxt  = 1'b0;
      fault_nxt    = STAT_OK;
      seg_nxt      = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      esc_r      <= 1'b0;
      pair_exp_r <= 1'b0;
      seen_eq_r  <= 1'b0;
      fault_r    <= STAT_OK;
      seg_r      <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      esc_r      <= esc_nxt;
      pair_exp_r <= pair_exp_nxt;
      seen_eq_r  <= seen_eq_nxt;
      fault_r    <= fault_nxt;
      seg_r      <= seg_nxt;
    end
  end

  // Only bytes that cause results enter the queue
  assign bundle = bnd;
  assign push   = accept && (bnd.has_char || bnd.has_pair || bnd.has_fin);

endmodule

// ===== rtl/ospp_queue.sv =====
module ospp_queue #(
  parameter int DEPTH = ospp_pkg::OSPP_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ospp_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output ospp_pkg::bundle_t q_data
);
  import ospp_pkg::*;

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/ospp_back.sv =====
module ospp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ospp_pkg::bundle_t q_data,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [7:0] char_data, [9:8] status, rest zero
  output logic [1:0]        out_tuser,   // [1:0] kind
  output logic              out_tlast    // last_of_run
);
  import ospp_pkg::*;

  bundle_t work_r, work_nxt;
  logic    work_valid_r, work_valid_nxt;
  logic    fire;
  logic    single;
  kind_t   cur_kind;
  logic [7:0] cur_data;
  status_t cur_status;

  // Only one pending result left in the bundle
  assign single = (work_r.has_char ^ work_r.has_pair ^ work_r.has_fin) &&
                  !(work_r.has_char && work_r.has_pair && work_r.has_fin);
  assign fire   = work_valid_r && out_tready;
  assign pop    = q_valid && (!work_valid_r || (fire && single));

  // Lowest pending result goes out first
  always_comb begin
    cur_kind   = KIND_FINISHED;
    cur_data   = '0;
    cur_status = STAT_OK;
    if (work_r.has_char) begin
      cur_kind = work_r.char_kind;
      cur_data = work_r.char_data;
    end else if (work_r.has_pair) begin
      cur_kind = KIND_PAIR;
    end else begin
      cur_status = work_r.status;
    end
  end

  // Retire results one by one, reload from the queue
  always_comb begin
    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    if (fire) begin
      if (work_r.has_char)      work_nxt.has_char = 1'b0;
      else if (work_r.has_pair) work_nxt.has_pair = 1'b0;
      else                      work_nxt.has_fin  = 1'b0;
      if (single) work_valid_nxt = 1'b0;
    end
    if (pop) begin
      work_nxt       = q_data;
      work_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign out_tvalid = work_valid_r;
  assign out_tdata  = {6'b0, cur_status, cur_data};
  assign out_tuser  = cur_kind;
  assign out_tlast  = single;

endmodule

// ===== rtl/option_string_pair_parser_unit.sv =====
// Option string pair parser.
// in_*  : one byte of an options string per transaction; in_tdata[7:0] is the
//         byte, in_tlast marks the last byte of the buffer. A zero byte ends the
//         string at once.
// out_* : result transactions; out_tuser is the kind (name byte, value byte,
//         pair complete, finished), out_tdata[7:0] the unescaped byte,
//         out_tdata[9:8] the finished status (ok, syntax error, too long),
//         out_tlast marks the final result caused by one input byte.
// Throughput: one input byte per cycle while the queue is not full. Each byte
//   causes zero to three results; the output side delivers one result per
//   cycle while out_tready is high. Bytes with none (separators, option
//   prefixes, escapes) do not enter the queue and never occupy the output.
// Path: the results of a byte are written into the queue, then loaded into the
//   output stage register before they are presented on out_*.
// A four-entry queue sits between parser and output stage; in_tready falls
//   only while it is full, so a stalled receiver backs up into the input once
//   four bytes with results wait behind the one held in the output stage.
//   Results are held stable while out_tready is low.
// Reset: synchronous, active low; parser state returns to idle between tokens
//   and queue and output stage empty. No clearing pass follows reset.
module option_string_pair_parser_unit #(
  parameter int MAX_VAR_BYTES = ospp_pkg::OSPP_MAX_VAR_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] char_data, [9:8] status, rest zero
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast    // last_of_run
);
  import ospp_pkg::*;

  logic    accept;
  logic    push;
  bundle_t push_data;
  logic    q_full;
  logic    q_valid;
  bundle_t q_data;
  logic    pop;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Front: parse and classify each byte
  ospp_front #(
    .MAX_VAR_BYTES(MAX_VAR_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .is_last (in_tlast),
    .push    (push),
    .bundle  (push_data)
  );

  // Queue of result bundles
  ospp_queue #(
    .DEPTH(OSPP_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back: serialise bundles into result transactions
  ospp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // A finished result is always the last one of its byte
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_FINISHED)) |-> out_tlast)
    else $error("finished result not marked last of run");

  // Status is only carried by finished results
  a_status_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_FINISHED)) |-> (out_tdata[9:8] == STAT_OK))
    else $error("status set on a non-finished result");

  // Out of reset the block is empty and ready
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (in_tready && !out_tvalid))
    else $error("block not empty after reset");
`endif

endmodule

// ===== sim/ospp_result_checker.sv =====
`timescale 1ns / 100ps

module ospp_result_checker #(
  parameter int MAX_VAR_BYTES = ospp_pkg::OSPP_MAX_VAR_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // is_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [7:0] char_data, [9:8] status, rest zero
  input  logic [1:0]  out_tuser,   // [1:0] kind
  input  logic        out_tlast,   // last_of_run
  output int          mismatches,
  output int          outstanding
);
  import ospp_pkg::*;

  typedef enum logic [2:0] {
    SCAN_GAP,
    SCAN_DASH,
    SCAN_OPT_C,
    SCAN_DDASH,
    SCAN_PAIR,
    SCAN_MUTE
  } scan_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  // Shadow parser state
  scan_t   scan_state;
  logic    esc_pending;
  logic    pair_due;
  logic    got_equals;
  status_t fault;
  int      seg_len;

  // Results of the byte being parsed, then the in-order store of them
  result_t byte_res[3];
  int      byte_res_n;
  result_t parsed_results[$];
  result_t oldest;
  int      err_count = 0;

  function automatic void clear_parser();
    scan_state  = SCAN_GAP;
    esc_pending = 1'b0;
    pair_due    = 1'b0;
    got_equals  = 1'b0;
    fault       = STAT_OK;
    seg_len     = 0;
  endfunction

  function automatic void emit(input kind_t k, input logic [7:0] d, input status_t s);
    if (byte_res_n < 3) begin
      byte_res[byte_res_n].kind   = k;
      byte_res[byte_res_n].data   = d;
      byte_res[byte_res_n].status = s;
      byte_res[byte_res_n].last   = 1'b0;
      byte_res_n++;
    end
  endfunction

  // First fault decides the status; parser goes quiet until the end
  function automatic void raise_fault(input status_t code);
    if (fault == STAT_OK)
      fault = code;
    scan_state = SCAN_MUTE;
  endfunction

  function automatic void start_pair();
    scan_state  = SCAN_PAIR;
    got_equals  = 1'b0;
    esc_pending = 1'b0;
    seg_len     = 0;
  endfunction

  // One byte inside a name=value token
  function automatic void pair_char(input logic [7:0] b);
    if (!got_equals && b == CH_EQUALS) begin
      got_equals  = 1'b1;
      esc_pending = 1'b0;
      seg_len     = 0;
    end else if (!esc_pending && b == CH_BACKSLASH) begin
      esc_pending = 1'b1;
    end else begin
      esc_pending = 1'b0;
      if (seg_len >= MAX_VAR_BYTES - 1) begin
        raise_fault(STAT_TOO_LONG);
      end else begin
        seg_len++;
        if (got_equals)
          emit(KIND_VALUE, b, STAT_OK);
        else
          emit(KIND_NAME, (b == CH_DASH) ? CH_UNDERSCORE : b, STAT_OK);
      end
    end
  endfunction

  // End of a token: separator, NUL or last byte
  function automatic void close_token();
    case (scan_state)
      SCAN_DASH, SCAN_DDASH: raise_fault(STAT_SYNTAX);
      SCAN_OPT_C: begin
        pair_due   = 1'b1;
        scan_state = SCAN_GAP;
      end
      SCAN_PAIR: begin
        if (got_equals) begin
          emit(KIND_PAIR, 8'h00, STAT_OK);
          scan_state = SCAN_GAP;
        end else begin
          raise_fault(STAT_SYNTAX);
        end
      end
      default: ;
    endcase
    esc_pending = 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    logic ws;
    logic done;
    int   k;
    byte_res_n = 0;
    done       = 1'b0;
    ws         = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    if (b == CH_NUL) begin
      close_token();
      done = 1'b1;
    end else begin
      case (scan_state)
        SCAN_GAP: begin
          if (!ws) begin
            if (pair_due) begin
              pair_due = 1'b0;
              start_pair();
              pair_char(b);
            end else if (b == CH_DASH) begin
              scan_state = SCAN_DASH;
            end else begin
              raise_fault(STAT_SYNTAX);
            end
          end
        end
        SCAN_DASH: begin
          if (ws)
            close_token();
          else if (b == CH_LOWER_C)
            scan_state = SCAN_OPT_C;
          else if (b == CH_DASH)
            scan_state = SCAN_DDASH;
          else
            raise_fault(STAT_SYNTAX);
        end
        SCAN_OPT_C: begin
          if (ws)
            close_token();
          else
            raise_fault(STAT_SYNTAX);
        end
        SCAN_DDASH: begin
          if (ws) begin
            close_token();
          end else begin
            start_pair();
            pair_char(b);
          end
        end
        SCAN_PAIR: begin
          if (ws && !esc_pending)
            close_token();
          else
            pair_char(b);
        end
        default: ;
      endcase
      if (last) begin
        close_token();
        done = 1'b1;
      end
    end
    if (done) begin
      // -c still waiting for its pair counts as a syntax error
      if (pair_due)
        raise_fault(STAT_SYNTAX);
      emit(KIND_FINISHED, 8'h00, fault);
      clear_parser();
    end
    if (byte_res_n > 0)
      byte_res[byte_res_n - 1].last = 1'b1;
    for (k = 0; k < byte_res_n; k++)
      parsed_results.push_back(byte_res[k]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      parsed_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (parsed_results.size() == 0) begin
          err_count++;
          $display("%0t: result expected none, got kind %0d tdata %0h tlast %0b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          oldest = parsed_results.pop_front();
          check_field("kind", 8'(oldest.kind), 8'(out_tuser));
          check_field("char_data", oldest.data, out_tdata[7:0]);
          check_field("status", 8'(oldest.status), 8'(out_tdata[9:8]));
          check_field("tdata pad", 8'h00, 8'(out_tdata[15:10]));
          check_field("tlast", 8'(oldest.last), 8'(out_tlast));
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= parsed_results.size();
  end

endmodule

// ===== sim/tb_option_string_pair_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_option_string_pair_parser_unit;
  import ospp_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 2000;
  localparam int PHASE_BYTES    = 10;
  localparam int TAIL_CYCLES    = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;

  // Traffic shaping
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit hold_req   = 1'b0;
  bit hold_seen  = 1'b0;
  int hold_left  = 0;
  int quiet_cycles = 0;
  int sent_bytes = 0;

  logic [7:0] text_q[$];

  always #5 clk = ~clk;

  option_string_pair_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ospp_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("option_string_pair_parser_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] ws_byte();
    if ($urandom_range(1))
      return CH_SPACE;
    return CH_TAB + 8'($urandom_range(4));
  endfunction

  function automatic logic [7:0] plain_byte(input bit allow_equals);
    logic [7:0] b;
    do
      b = 8'($urandom_range(1, 255));
    while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_BACKSLASH ||
           (!allow_equals && b == CH_EQUALS));
    return b;
  endfunction

  function automatic void add_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++)
      text_q.push_back(s[k]);
  endfunction

  function automatic void add_run(input logic [7:0] b, input int count);
    repeat (count) text_q.push_back(b);
  endfunction

  function automatic void add_gap();
    repeat ($urandom_range(1, 2)) text_q.push_back(ws_byte());
  endfunction

  // Name or value: mostly short, sometimes around the length limit
  function automatic void add_segment(input bit is_value);
    int len;
    int k;
    if ($urandom_range(11) == 0)
      len = $urandom_range(60, 66);
    else
      len = $urandom_range(is_value ? 0 : 1, 6);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0: text_q.push_back(CH_DASH);
        1: begin
          text_q.push_back(CH_BACKSLASH);
          text_q.push_back(8'($urandom_range(1, 255)));
        end
        2: begin
          text_q.push_back(CH_BACKSLASH);
          text_q.push_back(ws_byte());
        end
        default: text_q.push_back(plain_byte(is_value));
      endcase
    end
  endfunction

  function automatic void add_pair();
    add_segment(1'b0);
    if ($urandom_range(11) != 0)
      text_q.push_back(CH_EQUALS);
    add_segment(1'b1);
  endfunction

  // Mostly well-formed option strings, some noise and broken tokens
  function automatic void build_random_string();
    int n;
    int k;
    int r;
    text_q.delete();
    if ($urandom_range(9) < 2) begin
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(5))
          0: text_q.push_back(CH_DASH);
          1: text_q.push_back(CH_LOWER_C);
          2: text_q.push_back(CH_EQUALS);
          3: text_q.push_back(CH_BACKSLASH);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(3) == 0)
        text_q.push_back(ws_byte());
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) begin
        if (k > 0)
          add_gap();
        r = $urandom_range(9);
        if (r < 4) begin
          add_text("-c");
          add_gap();
          add_pair();
        end else if (r < 8) begin
          add_text("--");
          add_pair();
        end else if (r == 8) begin
          add_text("-c");
        end else begin
          text_q.push_back(CH_DASH);
          if ($urandom_range(1))
            text_q.push_back(8'($urandom_range(1, 255)));
        end
      end
      if ($urandom_range(3) == 0)
        text_q.push_back(ws_byte());
    end
  endfunction

  // One input transaction, with random idle cycles before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
  endtask

  // Send the built string, ended by tlast on its final byte or by a NUL
  task automatic send_text(input bit mark_last);
    int k;
    logic last;
    if (!mark_last || text_q.size() == 0)
      text_q.push_back(CH_NUL);
    for (k = 0; k < text_q.size(); k++) begin
      if (k != text_q.size() - 1)
        last = 1'b0;
      else
        last = mark_last ? 1'b1 : 1'($urandom_range(1));
      send_byte(text_q[k], last);
    end
    text_q.delete();
  endtask

  task automatic send_plain(input string s, input bit mark_last);
    text_q.delete();
    add_text(s);
    send_text(mark_last);
  endtask

  initial begin
    int ph;
    int start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings
    send_plain("--a-b=x\\ y", 1'b1);
    send_plain("-c n=v", 1'b0);
    send_plain("-c", 1'b1);
    send_plain("--", 1'b0);
    send_plain("- x", 1'b0);
    send_plain("--abc", 1'b1);
    send_plain("x --a=b", 1'b0);
    send_plain("--a=b y", 1'b0);
    send_plain("--k=v\\", 1'b1);
    send_plain("--k=\\", 1'b0);
    send_plain("--\\=x=y", 1'b1);
    send_plain("-cx", 1'b0);
    send_plain("-c --a=b", 1'b0);
    send_plain("", 1'b0);
    text_q.delete();
    add_text("\t--\\\\q=");
    text_q.push_back(8'hff);
    add_text("==\r");
    send_text(1'b1);
    // Name right at the limit, then one byte over; value over
    text_q.delete();
    add_text("--");
    add_run("n", 63);
    add_text("=v");
    send_text(1'b1);
    text_q.delete();
    add_text("--");
    add_run("n", 64);
    add_text("=v");
    send_text(1'b0);
    text_q.delete();
    add_text("--n=");
    add_run("v", 64);
    send_text(1'b0);

    // Random strings over the idle and stall phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 84; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 84; end
        default: begin idle_pct = 19; stall_pct <= 19; end
      endcase
      start = sent_bytes;
      while (sent_bytes - start < PHASE_BYTES) begin
        build_random_string();
        send_text(1'($urandom_range(1)));
      end
    end

    // Long receiver hold-off while bytes keep coming
    idle_pct = 0;
    stall_pct <= 0;
    hold_req  <= ~hold_req;
    text_q.delete();
    add_text("--");
    add_run("p", 8);
    text_q.push_back(CH_EQUALS);
    add_run("q", 8);
    send_text(1'b1);

    // Drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("option_string_pair_parser_unit: match");
    else
      $display("option_string_pair_parser_unit: mismatch");
    $finish;
  end

endmodule
